/* src/xrr_pkg.sv */
// shared constants, codes and control types for the xorshift range unit
package xrr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);
  localparam int unsigned MODE_W = 2;

  localparam logic [WORD_W-1:0] SEED_X = 32'd123456789;
  localparam logic [WORD_W-1:0] SEED_Y = 32'd362436069;
  localparam logic [WORD_W-1:0] SEED_Z = 32'd521288629;
  localparam logic [WORD_W-1:0] SEED_W = 32'd88675123;

  localparam int unsigned SHIFT_T_LEFT  = 11;
  localparam int unsigned SHIFT_W_RIGHT = 19;
  localparam int unsigned SHIFT_T_RIGHT = 8;

  localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } xrr_cmd_t;

  typedef struct packed {
    logic bypass;
    logic last;
    logic out_free;
  } xrr_status_t;

endpackage

/* src/xrr_req_if.sv */
// request channel: valid/ready with mode and range operands
interface xrr_req_if
  import xrr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [WORD_W-1:0]        modulus_or_high;
  logic signed [WORD_W-1:0] range_low;

  modport source (output valid, output mode, output modulus_or_high, output range_low,
                  input ready);
  modport sink (input valid, input mode, input modulus_or_high, input range_low,
                output ready);
endinterface

/* src/xrr_rsp_if.sv */
// response channel: valid/ready with result word and error flag
interface xrr_rsp_if
  import xrr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              divide_by_zero;

  modport source (output valid, output value, output divide_by_zero, input ready);
  modport sink (input valid, input value, input divide_by_zero, output ready);
endinterface

/* src/xrr_ctrl.sv */
// controller state machine sequencing load, remainder steps and result write
module xrr_ctrl
  import xrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  xrr_status_t status,
  output xrr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = RUN;
        end
      end
      RUN: begin
        if (status.bypass) begin
          state_next = DONE;
        end else begin
          cmd.step = 1'b1;
          if (status.last) state_next = DONE;
        end
      end
      DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end

endmodule

/* src/xrr_datapath.sv */
// generator state, bit-serial remainder unit and result register
module xrr_datapath
  import xrr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  xrr_cmd_t                 cmd,
  output xrr_status_t              status,
  input  logic [MODE_W-1:0]        mode,
  input  logic [WORD_W-1:0]        modulus_or_high,
  input  logic signed [WORD_W-1:0] range_low,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [WORD_W-1:0]        out_value,
  output logic                     out_dbz
);

  logic [WORD_W-1:0] word_x, word_y, word_z, word_w;
  logic [WORD_W-1:0] t_mix, w_next;
  logic [WORD_W-1:0] word, modulus, low, rem;
  logic [MODE_W-1:0] mode_q;
  logic              bypass, dbz;
  logic [CNT_W-1:0]  count;
  logic              is_div_mode;
  logic [WORD_W-1:0] modulus_next;
  logic [WORD_W:0]   rem_sh, diff;
  logic [WORD_W-1:0] result_next;

  assign t_mix  = word_x ^ (word_x << SHIFT_T_LEFT);
  assign w_next = (word_w ^ (word_w >> SHIFT_W_RIGHT)) ^ (t_mix ^ (t_mix >> SHIFT_T_RIGHT));

  assign is_div_mode  = (mode == MODE_MOD) || (mode == MODE_RANGE);
  assign modulus_next = (mode == MODE_MOD) ? modulus_or_high
                                           : modulus_or_high - WORD_W'(range_low) + 1'b1;

  assign rem_sh = {rem, word[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, modulus};

  always_comb begin
    if (bypass) result_next = dbz ? '0 : word;
    else if (mode_q == MODE_RANGE) result_next = rem + low;
    else result_next = rem;
  end

  assign status.bypass   = bypass;
  assign status.last     = (count == CNT_W'(WORD_W - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_x <= SEED_X;
      word_y <= SEED_Y;
      word_z <= SEED_Z;
      word_w <= SEED_W;
    end else if (cmd.load) begin
      word_x <= word_y;
      word_y <= word_z;
      word_z <= word_w;
      word_w <= w_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word    <= w_next;
      mode_q  <= mode;
      low     <= WORD_W'(range_low);
      modulus <= modulus_next;
      bypass  <= !is_div_mode || (modulus_next == '0);
      dbz     <= is_div_mode && (modulus_next == '0);
      rem     <= '0;
      count   <= '0;
    end else if (cmd.step) begin
      rem   <= diff[WORD_W] ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
      word  <= word << 1;
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value <= result_next;
      out_dbz   <= dbz;
    end
  end

endmodule

/* src/xorshift_random_in_range_unit.sv */
// top level: xorshift128 generator with modulo and signed range reduction
//
//   channel  dir  payload
//   req      in   mode, modulus_or_high, range_low
//   rsp      out  value, divide_by_zero
//
// one request at a time; a transaction in modulo and range modes is accept,
// 32 steps of the bit-serial remainder unit and result write; raw mode or a
// zero modulus skips the remainder steps
// rst is synchronous; it reloads the four seed words and empties the result register
// a new request is taken while a result waits in the result register;
// the final write stalls only while that register is still full
module xorshift_random_in_range_unit
  import xrr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  xrr_req_if.sink req,
  xrr_rsp_if.source rsp
);

  xrr_cmd_t    cmd;
  xrr_status_t status;

  xrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  xrr_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (req.mode),
    .modulus_or_high (req.modulus_or_high),
    .range_low       (req.range_low),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_value       (rsp.value),
    .out_dbz         (rsp.divide_by_zero)
  );

endmodule
